>>> src/fpps_pkg.sv
`timescale 1ns / 1ps

package fpps_pkg;

  localparam int NUM_ENTRIES_DEF = 32;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] RESET_PRIORITY = 8'd40;
  localparam logic [7:0] RESET_QUANTUM  = 8'd50;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READY  = 3'd1,
    OP_RESUME = 3'd2,
    OP_STOP   = 3'd3,
    OP_YIELD  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PS_READY   = 2'd0,
    PS_RUNNING = 2'd1,
    PS_STOPPED = 2'd2,
    PS_WAITING = 2'd3
  } pstate_t;

  typedef enum logic [1:0] {
    EV_ALARM    = 2'd0,
    EV_CHILD    = 2'd1,
    EV_DISPATCH = 2'd2
  } event_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_USER_PRIORITY  = 1'd0,
    REG_QUANTUM_LENGTH = 1'd1
  } reg_index_t;

  // one row of the process table
  typedef struct packed {
    logic        valid;
    logic [1:0]  pstate;
    logic [7:0]  prio;
    logic [31:0] alarm;
    logic [4:0]  parent;
    logic [7:0]  quantum;
  } entry_t;

  // one input item as unpacked from the stream
  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  target;
    logic        valid;
    logic [1:0]  pstate;
    logic [7:0]  prio;
    logic [31:0] alarm;
    logic [4:0]  parent;
    logic [31:0] now;
  } job_t;

  function automatic entry_t reset_entry(input logic idle);
    entry_t e;
    e.valid   = idle;
    e.pstate  = idle ? PS_RUNNING : PS_READY;
    e.prio    = RESET_PRIORITY;
    e.alarm   = '0;
    e.parent  = '0;
    e.quantum = '0;
    return e;
  endfunction

endpackage

>>> src/fixed_priority_process_scheduler.sv
`timescale 1ns / 1ps

// Fixed-priority process scheduler. The process table sits in a memory with
// one read port and one write port, and one sequencer walks it one entry per
// cycle while no alarm result is held by a full output register. Load, make
// ready and resume read the target entry, then write it back. Stop and yield
// update the current entry, scan entries 1..NUM_ENTRIES-1 through the table
// read port, which fires expired alarms and finds the ready entry with the
// smallest signed priority, then read and write the chosen entry; a result
// that finds the output register still full holds the sequencer until it
// drains. Unknown operations are accepted and dropped.
// The block accepts a new item only after the previous one has finished;
// results wait in an output register. No clearing pass is needed after reset:
// per-entry written bits make untouched entries read as their reset value.
module fixed_priority_process_scheduler #(
  parameter int NUM_ENTRIES = fpps_pkg::NUM_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // target_index, entry_valid, state_value, priority_value, alarm_value,
  // parent_index, current_time
  input  logic [fpps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [fpps_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_target, context_switch
  output logic [fpps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // event_kind
  output logic [fpps_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  // last_result
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fpps_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR_WR,
    S_SCAN,
    S_PICK_RD,
    S_PICK_WR
  } seq_t;

  seq_t          state;
  job_t          job;
  job_t          in_job;
  logic [IW-1:0] addr_q;
  logic [IW-1:0] cur;
  logic [7:0]    user_priority;
  logic [7:0]    quantum_length;

  logic [CW-1:0] scan_idx;
  logic [IW-1:0] ex_idx;
  logic          ex_vld;
  logic          found;
  logic [IW-1:0] best;
  logic [7:0]    best_prio;

  logic [4:0]    ev_target;
  logic          ev_switch;
  logic [1:0]    ev_kind;
  logic          ev_last;

  // table memory
  entry_t        mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] wr_ok;
  entry_t        rd_data;
  logic          rd_ok_q;
  logic [IW-1:0] rd_addr_q;

  logic          rd_en;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;

  entry_t        ent;
  logic          out_free;
  logic          alarm_hit;
  logic          ready_hit;
  logic          stall;
  logic          emit;
  logic          in_ctl;
  logic          tgt_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {2'b00, ev_switch, ev_target};
  assign m_axis_tuser  = ev_kind;
  assign m_axis_tlast  = ev_last;

  always_comb begin
    in_job.op     = s_axis_tuser;
    in_job.target = s_axis_tdata[4:0];
    in_job.valid  = s_axis_tdata[5];
    in_job.pstate = s_axis_tdata[7:6];
    in_job.prio   = s_axis_tdata[15:8];
    in_job.alarm  = s_axis_tdata[47:16];
    in_job.parent = s_axis_tdata[52:48];
    in_job.now    = s_axis_tdata[84:53];
  end

  assign in_ctl = (s_axis_tuser == OP_STOP) || (s_axis_tuser == OP_YIELD);
  assign tgt_ok = (7'(s_axis_tdata[4:0]) < 7'(NUM_ENTRIES));

  always_comb begin
    ent       = rd_ok_q ? rd_data : reset_entry(rd_addr_q == '0);
    out_free  = !m_axis_tvalid || m_axis_tready;
    alarm_hit = ent.valid && (ent.alarm != '0) && (ent.alarm < job.now);
    ready_hit = ent.valid && (ent.pstate == PS_READY);
    stall     = 1'b0;
    emit      = 1'b0;
    rd_en     = 1'b0;
    raddr     = cur;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = ent;
    unique case (state)
      S_IDLE: begin
        rd_en = s_axis_tvalid;
        raddr = in_ctl ? cur : IW'(in_job.target);
      end
      S_CUR_WR: begin
        priority case (job.op)
          OP_LOAD: begin
            we            = 1'b1;
            wdata.valid   = job.valid;
            wdata.pstate  = job.pstate;
            wdata.prio    = job.prio;
            wdata.alarm   = job.alarm;
            wdata.parent  = job.parent;
          end
          OP_READY: begin
            we           = 1'b1;
            wdata.pstate = PS_READY;
          end
          OP_RESUME: begin
            we           = (ent.pstate == PS_STOPPED);
            wdata.pstate = PS_READY;
          end
          OP_STOP: begin
            we           = out_free;
            emit         = out_free;
            wdata.pstate = PS_STOPPED;
          end
          OP_YIELD: begin
            we           = (ent.pstate == PS_RUNNING);
            wdata.pstate = PS_READY;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        stall       = ex_vld && alarm_hit && !out_free;
        we          = ex_vld && alarm_hit && out_free;
        emit        = ex_vld && alarm_hit && out_free;
        waddr       = ex_idx;
        wdata.alarm = '0;
        rd_en       = !stall && (scan_idx < CW'(NUM_ENTRIES));
        raddr       = scan_idx[IW-1:0];
      end
      S_PICK_RD: begin
        rd_en = 1'b1;
        raddr = best;
      end
      S_PICK_WR: begin
        we            = out_free;
        emit          = out_free;
        waddr         = best;
        wdata.prio    = user_priority;
        wdata.pstate  = PS_RUNNING;
        wdata.quantum = quantum_length;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data   <= mem[raddr];
      rd_addr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ok <= '0;
    end else if (we) begin
      wr_ok[waddr] <= 1'b1;
    end
    if (rd_en) begin
      rd_ok_q <= wr_ok[raddr] && !rst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cur            <= '0;
      user_priority  <= RESET_PRIORITY;
      quantum_length <= RESET_QUANTUM;
      m_axis_tvalid  <= 1'b0;
      ex_vld         <= 1'b0;
      found          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_USER_PRIORITY:  user_priority  <= cfg_data;
          REG_QUANTUM_LENGTH: quantum_length <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            job    <= in_job;
            addr_q <= in_ctl ? cur : IW'(in_job.target);
            if (in_ctl || (tgt_ok && (s_axis_tuser == OP_LOAD ||
                s_axis_tuser == OP_READY || s_axis_tuser == OP_RESUME))) begin
              state <= S_CUR_WR;
            end
          end
        end
        S_CUR_WR: begin
          scan_idx <= CW'(1);
          ex_vld   <= 1'b0;
          found    <= 1'b0;
          best     <= '0;
          if (job.op == OP_STOP) begin
            if (out_free) begin
              ev_kind       <= EV_CHILD;
              ev_target     <= ent.parent;
              ev_switch     <= 1'b0;
              ev_last       <= 1'b0;
              state         <= S_SCAN;
            end
          end else if (job.op == OP_YIELD) begin
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (ex_vld) begin
              if (alarm_hit) begin
                ev_kind       <= EV_ALARM;
                ev_target     <= 5'(ex_idx);
                ev_switch     <= 1'b0;
                ev_last       <= 1'b0;
              end
              // first ready entry wins ties
              if (ready_hit && (!found || ($signed(ent.prio) < $signed(best_prio)))) begin
                found     <= 1'b1;
                best      <= ex_idx;
                best_prio <= ent.prio;
              end
            end
            if (scan_idx < CW'(NUM_ENTRIES)) begin
              ex_idx   <= scan_idx[IW-1:0];
              ex_vld   <= 1'b1;
              scan_idx <= scan_idx + CW'(1);
            end else begin
              ex_vld <= 1'b0;
              if (!ex_vld) begin
                state <= S_PICK_RD;
              end
            end
          end
        end
        S_PICK_RD: begin
          state <= S_PICK_WR;
        end
        S_PICK_WR: begin
          if (out_free) begin
            ev_kind       <= EV_DISPATCH;
            ev_target     <= 5'(best);
            ev_switch     <= (best != cur);
            ev_last       <= 1'b1;
            cur           <= best;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
